FILE: sv/dtfp_pkg.sv
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared types and constants of the decimal text to fixed-point parser.
// ----------------------------------------------------------------------------
package dtfp_pkg;

	localparam int FRAC_DIGITS = 4;
	localparam int SCALE_W     = 14;
	localparam int WHOLE_W     = 20;
	localparam int FRAC_W      = 14;
	localparam int NDIG_W      = 3;
	localparam int VALUE_W     = 22;
	localparam int PRODW_W     = WHOLE_W + SCALE_W;
	localparam int NUM_W       = 28;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [WHOLE_W-1:0] WHOLE_GUARD = 20'd100000;
	localparam logic [PRODW_W-1:0] VALUE_LIMIT = 34'd2000000;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 14'd1;
	// half of 10^FRAC_DIGITS, added before the final divide
	localparam logic [NUM_W-1:0]   ROUND_HALF  = 28'd5000;

	// divide by 10000 = 16 * 625: shift, then reciprocal multiply by 1/625
	localparam int                 DIV_SHIFT   = 4;
	localparam int                 Y_W         = NUM_W - DIV_SHIFT;
	localparam logic [Y_W-1:0]     RECIP_625   = 24'd6871947;
	localparam logic [Y_W-1:0]     DIV_ODD     = 24'd625;
	localparam int                 RECIP_SH    = 32;

	typedef logic [SCALE_W-1:0] scale_t;

	typedef struct packed {
		logic               bad;
		logic               neg;
		logic [WHOLE_W-1:0] whole;
		logic [FRAC_W-1:0]  frac;
		logic [NDIG_W-1:0]  ndig;
	} job_t;

	// multiplier that pads a fraction of ndig digits to FRAC_DIGITS digits
	function automatic logic [FRAC_W-1:0] fill_mult(input logic [NDIG_W-1:0] ndig);
		logic [FRAC_W-1:0] m;
		begin
			case (ndig)
				3'd0:    m = 14'd10000;
				3'd1:    m = 14'd1000;
				3'd2:    m = 14'd100;
				3'd3:    m = 14'd10;
				default: m = 14'd1;
			endcase
			return m;
		end
	endfunction

endpackage

FILE: sv/dtfp_ifs.sv
// ----------------------------------------------------------------------------
// dtfp_ifs
// Valid/ready channel interfaces: text bytes in, results out, scale writes.
// ----------------------------------------------------------------------------
interface dtfp_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       starts_number;
	logic       no_more;
	modport source (output valid, text_byte, starts_number, no_more, input ready);
	modport sink   (input valid, text_byte, starts_number, no_more, output ready);
endinterface

interface dtfp_result_if;
	logic               valid;
	logic               ready;
	logic signed [21:0] scaled_value;
	logic               ok;
	modport source (output valid, scaled_value, ok, input ready);
	modport sink   (input valid, scaled_value, ok, output ready);
endinterface

interface dtfp_cfg_if;
	logic        valid;
	logic        ready;
	logic [13:0] scale_factor;
	modport source (output valid, scale_factor, input ready);
	modport sink   (input valid, scale_factor, output ready);
endinterface

FILE: sv/decimal_text_to_fixed_point.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Streams ASCII text and returns one scaled signed value per decimal number.
// ----------------------------------------------------------------------------
// Channels: text (sink) takes one byte per transfer with starts_number and
// no_more flags; result (source) gives scaled_value and ok; cfg (sink) takes
// the 14-bit scale factor, always ready, reset value 1. Write cfg only while
// no run is in flight.
// Throughput: the parser takes one byte per cycle while the job queue has
// room. Only bytes that end a run make a job; the scaling unit takes one
// job at a time through its multiply / reciprocal / correct sequence.
// Path: a job waits in the queue, then takes 4 scaling steps (NORM, MUL,
// REC, FIX) before result.valid is registered.
// Stall: the result register holds until taken; the scaling unit then
// waits, the 4-entry queue fills and text.ready drops once it is full.
// Reset: arst_n clears the parser to idle, empties the queue, drops
// result.valid and restores the scale factor to 1.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point import dtfp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	dtfp_text_if.sink     text,
	dtfp_result_if.source result,
	dtfp_cfg_if.sink      cfg
);

	scale_t scale_q;   // multiplier for the parsed value
	logic   q_full;
	logic   push;
	job_t   push_job;
	logic   pop;
	logic   q_valid;
	job_t   q_job;

	// config writes always complete in one transfer
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scale_q <= SCALE_RESET;
		else if (cfg.valid)
			scale_q <= cfg.scale_factor;
	end

	// front: classify bytes, build a job when a run ends or is rejected
	dtfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// decouples the byte stream from the multi-cycle scaling
	dtfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	// back: scale, round, limit check and result register
	dtfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.scale   (scale_q),
		.q_valid (q_valid),
		.q_job   (q_job),
		.pop     (pop),
		.result  (result)
	);

endmodule

FILE: sv/dtfp_front.sv
// ----------------------------------------------------------------------------
// dtfp_front
// Byte-at-a-time parser: tracks sign, digits and point, emits one job per run.
// ----------------------------------------------------------------------------
module dtfp_front import dtfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dtfp_text_if.sink    text,
	input  logic         q_full,
	output logic         push,
	output job_t         push_job
);

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SIGN  = 3'd1;
	localparam logic [2:0] PH_WHOLE = 3'd2;
	localparam logic [2:0] PH_POINT = 3'd3;
	localparam logic [2:0] PH_FRAC  = 3'd4;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_5     = 8'h35;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_POINT = 8'h2E;

	function automatic logic is_term(input logic [7:0] b);
		begin
			return b == 8'h2C || b == 8'h7D || b == 8'h5D || b == 8'h7C ||
			       b == 8'h20 || b == 8'h0A || b == 8'h0D || b == 8'h25 ||
			       b == 8'hC2 || b == 8'h6B;
		end
	endfunction

	logic [2:0]         phase_q, phase_d;
	logic               neg_q, neg_d;
	logic [WHOLE_W-1:0] whole_q, whole_d;
	logic [FRAC_W-1:0]  frac_q, frac_d;
	logic [NDIG_W-1:0]  ndig_q, ndig_d;
	logic               rnd_q, rnd_d;

	logic       accept;
	logic       digit;
	logic [3:0] dval;
	logic       emit;
	logic       bad;

	assign text.ready = !q_full;
	assign accept     = text.valid && text.ready;
	assign digit      = text.text_byte >= CH_0 && text.text_byte <= CH_9;
	assign dval       = 4'(text.text_byte - CH_0);

	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		whole_d = whole_q;
		frac_d  = frac_q;
		ndig_d  = ndig_q;
		rnd_d   = rnd_q;
		emit    = 1'b0;
		bad     = 1'b0;
		if (text.starts_number) begin
			neg_d   = 1'b0;
			whole_d = '0;
			frac_d  = '0;
			ndig_d  = '0;
			rnd_d   = 1'b0;
			if (text.no_more) begin
				emit = 1'b1;
				bad  = 1'b1;
			end else if (text.text_byte == CH_MINUS || text.text_byte == CH_PLUS) begin
				neg_d   = text.text_byte == CH_MINUS;
				phase_d = PH_SIGN;
			end else if (digit) begin
				whole_d = WHOLE_W'(dval);
				phase_d = PH_WHOLE;
			end else begin
				emit = 1'b1;
				bad  = 1'b1;
			end
		end else if (phase_q == PH_IDLE) begin
			emit = 1'b0;
		end else if (text.no_more) begin
			emit = 1'b1;
			bad  = !(phase_q == PH_WHOLE || phase_q == PH_FRAC);
		end else begin
			unique case (phase_q)
				PH_SIGN: begin
					if (digit) begin
						whole_d = WHOLE_W'(dval);
						phase_d = PH_WHOLE;
					end else begin
						emit = 1'b1;
						bad  = 1'b1;
					end
				end
				PH_WHOLE: begin
					if (digit) begin
						if (whole_q > WHOLE_GUARD) begin
							emit = 1'b1;
							bad  = 1'b1;
						end else begin
							whole_d = WHOLE_W'(whole_q * WHOLE_W'(10)) + WHOLE_W'(dval);
						end
					end else if (text.text_byte == CH_POINT) begin
						phase_d = PH_POINT;
					end else begin
						emit = 1'b1;
						bad  = !is_term(text.text_byte);
					end
				end
				PH_POINT, PH_FRAC: begin
					if (digit) begin
						if (ndig_q < NDIG_W'(FRAC_DIGITS)) begin
							frac_d = FRAC_W'(frac_q * FRAC_W'(10)) + FRAC_W'(dval);
							ndig_d = ndig_q + NDIG_W'(1);
						end else if (!rnd_q) begin
							if (text.text_byte >= CH_5)
								frac_d = frac_q + FRAC_W'(1);
							rnd_d = 1'b1;
						end
						phase_d = PH_FRAC;
					end else begin
						emit = 1'b1;
						bad  = !(phase_q == PH_FRAC && is_term(text.text_byte));
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
		if (emit)
			phase_d = PH_IDLE;
	end

	// finishing job carries the state held before this byte
	assign push           = accept && emit;
	assign push_job.bad   = bad;
	assign push_job.neg   = neg_q;
	assign push_job.whole = whole_q;
	assign push_job.frac  = frac_q;
	assign push_job.ndig  = ndig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			whole_q <= '0;
			frac_q  <= '0;
			ndig_q  <= '0;
			rnd_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			whole_q <= whole_d;
			frac_q  <= frac_d;
			ndig_q  <= ndig_d;
			rnd_q   <= rnd_d;
		end
	end

endmodule

FILE: sv/dtfp_queue.sv
// ----------------------------------------------------------------------------
// dtfp_queue
// Small job FIFO between the parser and the scaling unit.
// ----------------------------------------------------------------------------
module dtfp_queue import dtfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output job_t q_job
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = count_q == QCNT_W'(QDEPTH);
	assign q_valid = count_q != '0;
	assign q_job   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("job pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("job popped from empty queue");

endmodule

FILE: sv/dtfp_back.sv
// ----------------------------------------------------------------------------
// dtfp_back
// Scaling unit: pads the fraction, multiplies by scale, rounds, checks range.
// ----------------------------------------------------------------------------
module dtfp_back import dtfp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  scale_t        scale,
	input  logic          q_valid,
	input  job_t          q_job,
	output logic          pop,
	dtfp_result_if.source result
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_NORM = 3'd1;
	localparam logic [2:0] B_MUL  = 3'd2;
	localparam logic [2:0] B_REC  = 3'd3;
	localparam logic [2:0] B_FIX  = 3'd4;

	logic [2:0]         state_q;
	job_t               job_q;
	logic [FRAC_W-1:0]  fracn_q;
	logic [PRODW_W-1:0] prodw_q;
	logic [NUM_W-1:0]   num_q;
	logic [Y_W-1:0]     y_q;
	logic [FRAC_W-1:0]  qe_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic                      out_ok_q;

	logic [2*FRAC_W-1:0] fill_prod;
	logic [2*Y_W-1:0]    recip_prod;
	logic [Y_W-1:0]      y;
	logic [Y_W-1:0]      rem;
	logic [FRAC_W-1:0]   qfix;
	logic [VALUE_W-1:0]  mag;
	logic                over;
	logic                out_free;

	assign out_free   = !out_valid_q || result.ready;
	assign pop        = state_q == B_IDLE && q_valid;

	assign fill_prod  = job_q.frac * fill_mult(job_q.ndig);
	assign y          = num_q[NUM_W-1:DIV_SHIFT];
	assign recip_prod = y * RECIP_625;
	assign rem        = y_q - Y_W'(qe_q * DIV_ODD);
	assign qfix       = (rem >= DIV_ODD) ? qe_q + FRAC_W'(1) : qe_q;
	assign over       = prodw_q > VALUE_LIMIT;
	assign mag        = prodw_q[VALUE_W-1:0] + VALUE_W'(qfix);

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: if (pop) job_q <= q_job;
			B_NORM: begin
				fracn_q <= fill_prod[FRAC_W-1:0];
				prodw_q <= job_q.whole * scale;
			end
			B_MUL:  num_q <= NUM_W'(fracn_q * scale) + ROUND_HALF;
			B_REC: begin
				y_q  <= y;
				qe_q <= recip_prod[RECIP_SH+FRAC_W-1:RECIP_SH];
			end
			B_FIX: begin
				if (out_free) begin
					out_ok_q    <= !(job_q.bad || over);
					out_value_q <= (job_q.bad || over) ? '0 :
					               job_q.neg ? -signed'(mag) : signed'(mag);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: if (pop) state_q <= B_NORM;
				B_NORM: state_q <= B_MUL;
				B_MUL:  state_q <= B_REC;
				B_REC:  state_q <= B_FIX;
				B_FIX:  if (out_free) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if (state_q == B_FIX && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.scaled_value = out_value_q;
	assign result.ok           = out_ok_q;

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ok_q |-> out_value_q == '0)
		else $error("rejected result carries a nonzero value");

	// whole * scale stays within the limit; the rounded fraction adds at most scale
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ok_q |->
		out_value_q <= 22'sd2016383 && out_value_q >= -22'sd2016383)
		else $error("accepted result out of range");

	a_pop_starts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == B_NORM)
		else $error("popped job did not enter the scaling sequence");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for decimal_text_to_fixed_point. Byte runs go in on the
// text channel. A behavioral parser in the bench predicts every result, and
// each result that comes out is compared with the oldest prediction. The run
// walks through scale settings from zero to full scale, with random idle
// cycles on both sides and one long receiver hold-off that backs up the
// parser.
// ----------------------------------------------------------------------------
module tb_top;
	import dtfp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// bench knobs
	localparam int CYCLE_LIMIT  = 300000; // slowest legal run is far below this
	localparam int RUN_ITEMS    = 130;    // counted bytes per random scale phase
	localparam int HOLD_CYCLES  = 150;    // receiver hold-off length
	localparam int DRAIN_CYCLES = 12;     // extra wait after the last result comes back
	localparam int IDLE_PCT     = 35;     // idle cycles per hundred, each side

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_C2 = 8'hC2;
	localparam logic [7:0] TERM_BYTES [10] =
		'{",", "}", "]", "|", " ", CH_LF, CH_CR, "%", CH_C2, "k"};

	typedef enum logic [2:0] {PH_IDLE, PH_SIGN, PH_WHOLE, PH_POINT, PH_FRAC} parse_phase_e;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               ok;
	} outcome_t;

	logic clk;
	logic arst_n;

	dtfp_text_if   text_ch();
	dtfp_result_if result_ch();
	dtfp_cfg_if    cfg_ch();

	decimal_text_to_fixed_point dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------------
	// Parser shadow: state of the run in progress plus the scale register.
	// ------------------------------------------------------------------------
	parse_phase_e       ph = PH_IDLE;
	bit                 is_neg;
	logic [WHOLE_W-1:0] whole_acc;
	logic [FRAC_W-1:0]  frac_acc;
	int                 frac_cnt;
	bit                 round_seen;
	logic [SCALE_W-1:0] scale_reg = SCALE_RESET;

	// predicted results, oldest first
	outcome_t awaited_values[$];

	int  fail_count;
	int  items_sent;    // bytes that the parser acts on; idle filler not counted
	int  value_count;   // checked results with ok = 1
	int  reject_count;  // checked results with ok = 0
	int  scale_writes;
	int  cycle_count;
	bit  steady;        // no idling on either side while set
	bit  hold_req;      // asks the receiver for one long hold-off

	function automatic bit is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_term(input logic [7:0] b);
		foreach (TERM_BYTES[i])
			if (b == TERM_BYTES[i])
				return 1'b1;
		return 1'b0;
	endfunction

	// malformed run: zero value, ok low, back to idle
	function automatic bit drop_run(output outcome_t res);
		res = '0;
		ph  = PH_IDLE;
		return 1'b1;
	endfunction

	// well-formed end of run: range check, then sign * (whole*scale + rounded fraction)
	function automatic bit close_run(output outcome_t res);
		logic [63:0] sc;
		logic [63:0] dv;
		logic [63:0] mag;
		sc = 64'(scale_reg);
		dv = 64'd1;
		repeat (frac_cnt) dv = dv * 64'd10;
		// zero scale skips the limit test and yields zero
		if (sc != 64'd0 && 64'(whole_acc) > 64'(VALUE_LIMIT) / sc)
			return drop_run(res);
		mag = 64'(whole_acc) * sc + (64'(frac_acc) * sc + dv / 64'd2) / dv;
		if (is_neg)
			mag = 64'd0 - mag;
		res.value = mag[VALUE_W-1:0];
		res.ok    = 1'b1;
		ph        = PH_IDLE;
		return 1'b1;
	endfunction

	// one accepted byte; returns 1 when it ends a run and fills res
	function automatic bit parse_step(input logic [7:0] b, input bit first, input bit last,
			output outcome_t res);
		res = '0;
		if (first) begin
			// a start drops any run in progress without a result
			is_neg     = 1'b0;
			whole_acc  = '0;
			frac_acc   = '0;
			frac_cnt   = 0;
			round_seen = 1'b0;
			if (last)
				return drop_run(res);
			if (b == "-" || b == "+") begin
				is_neg = (b == "-");
				ph     = PH_SIGN;
				return 1'b0;
			end
			if (!is_digit(b))
				return drop_run(res);
			whole_acc = WHOLE_W'(b - "0");
			ph        = PH_WHOLE;
			return 1'b0;
		end
		if (ph == PH_IDLE)
			return 1'b0;
		if (last) begin
			if (ph == PH_WHOLE || ph == PH_FRAC)
				return close_run(res);
			return drop_run(res);
		end
		case (ph)
			PH_SIGN: begin
				if (!is_digit(b))
					return drop_run(res);
				whole_acc = WHOLE_W'(b - "0");
				ph        = PH_WHOLE;
				return 1'b0;
			end
			PH_WHOLE: begin
				if (is_digit(b)) begin
					if (whole_acc > WHOLE_GUARD)
						return drop_run(res);
					whole_acc = whole_acc * WHOLE_W'(10) + WHOLE_W'(b - "0");
					return 1'b0;
				end
				if (b == ".") begin
					ph = PH_POINT;
					return 1'b0;
				end
				if (is_term(b))
					return close_run(res);
				return drop_run(res);
			end
			default: begin
				if (is_digit(b)) begin
					if (frac_cnt < FRAC_DIGITS) begin
						frac_acc = frac_acc * FRAC_W'(10) + FRAC_W'(b - "0");
						frac_cnt++;
					end else if (!round_seen) begin
						// only the first dropped digit rounds
						if (b >= "5")
							frac_acc = frac_acc + FRAC_W'(1);
						round_seen = 1'b1;
					end
					ph = PH_FRAC;
					return 1'b0;
				end
				if (ph == PH_FRAC && is_term(b))
					return close_run(res);
				return drop_run(res);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Text side. Everything runs from the rising edge. valid is left high after
	// a transfer, so a back-to-back byte never lowers and raises it in one step;
	// pause_text is the only place that lowers it.
	// ------------------------------------------------------------------------
	task automatic pause_text(input int n);
		text_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
		outcome_t res;
		bit       ignored;
		if (!steady)
			while ($urandom_range(99) < IDLE_PCT)
				pause_text(1);
		text_ch.valid         <= 1'b1;
		text_ch.text_byte     <= b;
		text_ch.starts_number <= first;
		text_ch.no_more       <= last;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		// transfer done at this edge
		ignored = !first && ph == PH_IDLE;
		if (parse_step(b, first, last, res))
			awaited_values.push_back(res);
		if (!ignored)
			items_sent++;
	endtask

	// first byte carries the start flag, no terminator added
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == 0, 1'b0);
	endtask

	// closes an open run, lets every result come back, then waits out the pipe
	task automatic settle_block();
		if (ph != PH_IDLE)
			send_byte(8'h00, 1'b0, 1'b1);
		pause_text(1);
		while (awaited_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_scale(input logic [SCALE_W-1:0] s);
		settle_block();
		cfg_ch.valid        <= 1'b1;
		cfg_ch.scale_factor <= s;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		scale_reg = s;
		scale_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly well-formed numbers with random content; the rest is raw noise,
	// corrupted runs, missing digits and runs cut off by the next start.
	task automatic send_random_run();
		int          kind;
		int          ndig;
		logic [7:0]  seq[$];
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(255)), $urandom_range(99) < 30,
					$urandom_range(99) < 10);
			return;
		end
		case ($urandom_range(2))
			1: seq.push_back("+");
			2: seq.push_back("-");
			default: ;
		endcase
		// long integer parts are rare: they hit the guard and the value limit
		ndig = ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 7);
		repeat (ndig) seq.push_back(8'($urandom_range(9)) + "0");
		if ($urandom_range(99) < 60) begin
			seq.push_back(".");
			repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(9)) + "0");
		end
		if (kind < 25) begin
			seq[$urandom_range(seq.size() - 1)] = 8'($urandom_range(255));
		end else if (kind < 28) begin
			seq.delete();
			seq.push_back($urandom_range(1) ? "-" : "+");
		end else if (kind < 31) begin
			seq.push_back(".");
		end
		foreach (seq[i])
			send_byte(seq[i], i == 0, 1'b0);
		// a few runs get no terminator: the next start aborts them
		if (kind >= 31 && kind < 34)
			return;
		if ($urandom_range(99) < 85)
			send_byte(TERM_BYTES[$urandom_range(9)], 1'b0, 1'b0);
		else
			send_byte(8'($urandom_range(255)), 1'b0, 1'b1);
		// filler between runs, ignored by an idle parser
		if ($urandom_range(99) < 10)
			send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_directed_cases();
		send_byte(8'h00, 1'b0, 1'b0);      // stray byte while idle: ignored
		send_byte(8'hFF, 1'b0, 1'b1);      // end of data while idle: nothing
		send_byte("7", 1'b1, 1'b1);        // start with end of data: empty run
		send_byte("z", 1'b1, 1'b0);        // first byte neither sign nor digit
		send_text("+");
		send_byte(8'h00, 1'b0, 1'b1);      // sign then end of data
		send_text("-0.00005k");            // dropped 5 rounds up; negative zero
		send_text("9.");
		send_byte(8'hFF, 1'b0, 1'b0);      // point then foreign byte
		send_text("1234567");              // seventh digit overflows the whole part
	endtask

	task automatic test_scale_extremes();
		set_scale(14'd10000);
		send_text("201");
		send_byte(8'h00, 1'b0, 1'b1);      // over the value limit at this scale
		send_text("-200.5|");              // right at the limit
		set_scale(14'd0);
		send_text("7.25,");                // zero scale: zero value, still ok
		set_scale(14'd16383);
		send_text("122.9999 ");            // largest whole part allowed at full scale
	endtask

	// receiver holds off while short runs keep coming, so the job queue fills
	// and text ready drops; then the sender waits for every result
	task automatic test_backpressure();
		set_scale(14'd10);
		hold_req = 1'b1;
		repeat (40) begin
			send_byte(8'($urandom_range(9)) + "0", 1'b1, 1'b0);
			send_byte(",", 1'b0, 1'b0);
		end
		pause_text(1);
		while (awaited_values.size() != 0)
			@(posedge clk);
		repeat (10) send_random_run();
	endtask

	task automatic test_random_traffic();
		logic [SCALE_W-1:0] plan [7];
		int                 goal;
		plan = '{14'd1, 14'd10, 14'd10000, 14'd16383, 14'd0,
			SCALE_W'($urandom_range(1, 16383)), SCALE_W'($urandom_range(2, 9999))};
		foreach (plan[i]) begin
			set_scale(plan[i]);
			steady = (i == 3);  // one phase runs flat out on both sides
			goal   = items_sent + RUN_ITEMS;
			while (items_sent < goal)
				send_random_run();
			steady = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: random ready, one long hold-off counted here on request.
	// ------------------------------------------------------------------------
	initial begin
		int hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// each result transfer against the oldest prediction
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (awaited_values.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: value %0d ok %0b",
						result_ch.scaled_value, result_ch.ok);
			end else begin
				want = awaited_values.pop_front();
				if (want.ok)
					value_count++;
				else
					reject_count++;
				if (result_ch.scaled_value !== want.value || result_ch.ok !== want.ok) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: value exp %0d got %0d, ok exp %0b got %0b",
							$signed(want.value), result_ch.scaled_value, want.ok,
							result_ch.ok);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, awaited_values.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		arst_n                <= 1'b0;
		text_ch.valid         <= 1'b0;
		text_ch.text_byte     <= 8'h00;
		text_ch.starts_number <= 1'b0;
		text_ch.no_more       <= 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.scale_factor   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_scale_extremes();
		test_backpressure();
		test_random_traffic();
		settle_block();

		$display("covered %0d parsed bytes over %0d scale writes (zero to full scale)",
			items_sent, scale_writes);
		$display("checked %0d values and %0d rejects, incl. back-pressure and idle gaps",
			value_count, reject_count);
		if (fail_count == 0 && awaited_values.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
